// ===== hdl/olpd_pkg.sv =====
// olpd_pkg: command, status and cell operation codes for the ordered word store
// no dependencies; imported by olpd_cell and the top level
package olpd_pkg;

  // command codes of the input request
  localparam logic [2:0] CMD_APPEND     = 3'd0;
  localparam logic [2:0] CMD_DEL_HEAD   = 3'd1;
  localparam logic [2:0] CMD_DEL_TAIL   = 3'd2;
  localparam logic [2:0] CMD_DEL_POS    = 3'd3;
  localparam logic [2:0] CMD_DEL_CENTER = 3'd4;
  localparam logic [2:0] CMD_DUMP       = 3'd5;

  // result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // operation broadcast to every cell of the chain
  typedef logic [1:0] cell_op_t;
  localparam cell_op_t CELL_HOLD   = 2'd0;  // keep word
  localparam cell_op_t CELL_LOAD   = 2'd1;  // selected cell takes the append word
  localparam cell_op_t CELL_SHIFT  = 2'd2;  // cells at or above select take neighbor
  localparam cell_op_t CELL_ROTATE = 2'd3;  // below select take neighbor, select takes head

endpackage

// ===== hdl/olpd_cell.sv =====
// olpd_cell: one storage cell of the word chain
// depends on olpd_pkg for the cell operation codes
module olpd_cell import olpd_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int IDX_W      = 4,
  parameter int CELL_IDX   = 0
) (
  input  logic                  clk,
  input  cell_op_t              cell_op,
  input  logic [IDX_W-1:0]      cell_sel,
  input  logic [DATA_WIDTH-1:0] load_word,
  input  logic [DATA_WIDTH-1:0] next_word,
  input  logic [DATA_WIDTH-1:0] head_word,
  output logic [DATA_WIDTH-1:0] word
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [DATA_WIDTH-1:0] word_r;
  logic [DATA_WIDTH-1:0] word_nxt;

  // pick the new word from the broadcast operation
  always_comb begin
    word_nxt = word_r;
    case (cell_op)
      CELL_LOAD: begin
        if (MY_IDX == cell_sel) word_nxt = load_word;
      end
      CELL_SHIFT: begin
        if (MY_IDX >= cell_sel) word_nxt = next_word;
      end
      CELL_ROTATE: begin
        if (MY_IDX == cell_sel) word_nxt = head_word;
        else if (MY_IDX < cell_sel) word_nxt = next_word;
      end
      default: word_nxt = word_r;
    endcase
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

// ===== hdl/ordered_list_positional_delete_unit.sv =====
// ordered_list_positional_delete_unit: ordered word store built as a chain of cells
// depends on olpd_pkg and olpd_cell
//
// Usage:
//   Input channel (in_valid / in_stall) carries one command request: append,
//   delete head, delete tail, delete at 1-based position, delete center
//   (position ceil(count/2)) or dump. Result channel (out_valid / out_stall)
//   carries the results from one output register.
//   Every edit gives one result with its status and the new count in the cycle
//   after the request is taken; edits are taken one per cycle while no stall
//   or dump holds them, since every cell of the chain loads or shifts from its
//   neighbor in the same cycle. A dump of n words streams word 0 while the
//   live part of the chain rotates one place per word, so it gives n results
//   and blocks new requests until the last is loaded; last_of_run marks the
//   tail word. A dump of an empty store gives one ignored result.
//   Reset (rst_n low, synchronous) clears the count and the output valid;
//   the stored words are undefined until written and need no clearing pass.
//   When the receiver stalls, the output register holds its result and
//   in_stall rises; no request is lost or repeated.
module ordered_list_positional_delete_unit import olpd_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [2:0]                           in_command,
  input  logic signed [DATA_WIDTH-1:0]         in_value,
  input  logic [7:0]                           in_position,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [DATA_WIDTH-1:0]         out_element,
  output logic                                 out_element_valid,
  output logic [$clog2(DEPTH+1)-1:0]           out_count_after,
  output logic [1:0]                           out_status,
  output logic                                 out_last_of_run
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  // control state
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             dump_active_r, dump_active_nxt;
  logic [CNT_W-1:0] dump_left_r, dump_left_nxt;

  // output payload
  logic [DATA_WIDTH-1:0] out_element_r, out_element_nxt;
  logic                  out_elem_valid_r, out_elem_valid_nxt;
  logic [CNT_W-1:0]      out_count_r, out_count_nxt;
  logic [1:0]            out_status_r, out_status_nxt;
  logic                  out_last_r, out_last_nxt;

  // chain broadcast
  cell_op_t         cell_op;
  logic [IDX_W-1:0] cell_sel;
  logic [DATA_WIDTH-1:0] cell_word [DEPTH];

  logic       out_free;
  logic       in_acc;
  logic [7:0] del_pos;
  logic [7:0] count8;
  logic [CNT_W:0] center_sum;
  logic       del_ok;
  logic [7:0] del_idx;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = dump_active_r || !out_free;
  assign in_acc   = in_valid && !in_stall;

  // 1-based position of the word a delete removes
  assign count8     = 8'(count_r);
  assign center_sum = {1'b0, count_r} + {{CNT_W{1'b0}}, 1'b1};
  always_comb begin
    case (in_command)
      CMD_DEL_HEAD:   del_pos = 8'd1;
      CMD_DEL_TAIL:   del_pos = count8;
      CMD_DEL_CENTER: del_pos = 8'(center_sum[CNT_W:1]);
      default:        del_pos = in_position;
    endcase
  end
  assign del_ok  = (del_pos != 8'd0) && (del_pos <= count8);
  assign del_idx = del_pos - 8'd1;

  // request decode, dump sequencing and output register load
  always_comb begin
    cell_op            = CELL_HOLD;
    cell_sel           = '0;
    count_nxt          = count_r;
    dump_active_nxt    = dump_active_r;
    dump_left_nxt      = dump_left_r;
    out_valid_nxt      = out_valid_r;
    out_element_nxt    = out_element_r;
    out_elem_valid_nxt = out_elem_valid_r;
    out_count_nxt      = out_count_r;
    out_status_nxt     = out_status_r;
    out_last_nxt       = out_last_r;

    if (out_free) out_valid_nxt = 1'b0;

    if (dump_active_r && out_free) begin
      // stream head word and rotate the live part of the chain
      cell_op            = CELL_ROTATE;
      cell_sel           = IDX_W'(count_r - CNT_ONE);
      out_valid_nxt      = 1'b1;
      out_element_nxt    = cell_word[0];
      out_elem_valid_nxt = 1'b1;
      out_count_nxt      = count_r;
      out_status_nxt     = ST_DONE;
      out_last_nxt       = (dump_left_r == CNT_ONE);
      dump_left_nxt      = dump_left_r - CNT_ONE;
      if (dump_left_r == CNT_ONE) dump_active_nxt = 1'b0;
    end else if (in_acc) begin
      out_element_nxt    = '0;
      out_elem_valid_nxt = 1'b0;
      out_last_nxt       = 1'b1;
      out_status_nxt     = ST_IGNORED;
      out_valid_nxt      = 1'b1;
      case (in_command)
        CMD_APPEND: begin
          if (count_r == CNT_FULL) begin
            out_status_nxt = ST_FULL;
          end else begin
            cell_op        = CELL_LOAD;
            cell_sel       = IDX_W'(count_r);
            count_nxt      = count_r + CNT_ONE;
            out_status_nxt = ST_DONE;
          end
        end
        CMD_DEL_HEAD, CMD_DEL_TAIL, CMD_DEL_POS, CMD_DEL_CENTER: begin
          if (del_ok) begin
            cell_op        = CELL_SHIFT;
            cell_sel       = IDX_W'(del_idx);
            count_nxt      = count_r - CNT_ONE;
            out_status_nxt = ST_DONE;
          end
        end
        CMD_DUMP: begin
          // non-empty dump starts streaming next cycle
          if (count_r != '0) begin
            out_valid_nxt   = 1'b0;
            dump_active_nxt = 1'b1;
            dump_left_nxt   = count_r;
          end
        end
        default: out_status_nxt = ST_IGNORED;
      endcase
      out_count_nxt = count_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      count_r       <= '0;
      dump_active_r <= 1'b0;
      dump_left_r   <= '0;
    end else begin
      out_valid_r   <= out_valid_nxt;
      count_r       <= count_nxt;
      dump_active_r <= dump_active_nxt;
      dump_left_r   <= dump_left_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_element_r    <= out_element_nxt;
    out_elem_valid_r <= out_elem_valid_nxt;
    out_count_r      <= out_count_nxt;
    out_status_r     <= out_status_nxt;
    out_last_r       <= out_last_nxt;
  end

  // chain of cells, the top cell wraps to the head word
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    olpd_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IDX_W),
      .CELL_IDX   (gi)
    ) u_cell (
      .clk       (clk),
      .cell_op   (cell_op),
      .cell_sel  (cell_sel),
      .load_word (in_value),
      .next_word ((gi == DEPTH - 1) ? cell_word[0] : cell_word[(gi + 1) % DEPTH]),
      .head_word (cell_word[0]),
      .word      (cell_word[gi])
    );
  end

  assign out_valid         = out_valid_r;
  assign out_element       = out_element_r;
  assign out_element_valid = out_elem_valid_r;
  assign out_count_after   = out_count_r;
  assign out_status        = out_status_r;
  assign out_last_of_run   = out_last_r;

  // count stays within the chain
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("word count above depth");

  // no request is taken while a dump streams
  a_dump_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    dump_active_r |-> in_stall)
    else $error("request taken during dump");

  // the final dump word ends the dump
  a_dump_end: assert property (@(posedge clk) disable iff (!rst_n)
    (dump_active_r && out_free && dump_left_r == CNT_ONE) |=> !dump_active_r)
    else $error("dump did not end after tail word");

  // a result without an element is always the only one of its request
  a_noelem_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_elem_valid_r) |-> out_last_r)
    else $error("element-less result not marked last");

  // count changes only when a request is taken
  a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(count_r))
    else $error("count changed without a request");

endmodule

// ===== tb/sv/ordered_list_positional_delete_unit_test.sv =====
// ordered_list_positional_delete_unit_test: self-checking bench for the ordered word store
// depends on olpd_pkg and ordered_list_positional_delete_unit; predicts every result
`timescale 1ns / 1ps

module ordered_list_positional_delete_unit_test;
  import olpd_pkg::*;

  localparam int DEPTH          = 16;
  localparam int DATA_WIDTH     = 32;
  localparam int CNT_W          = $clog2(DEPTH + 1);
  localparam int CYCLE_LIMIT    = 200000;
  localparam int REQUEST_TARGET = 330;
  localparam int DRAIN_CYCLES   = 40;

  // codes outside the command set, answered as ignored
  localparam logic [2:0] CMD_RESERVED_A = 3'd6;
  localparam logic [2:0] CMD_RESERVED_B = 3'd7;

  typedef struct {
    logic signed [DATA_WIDTH-1:0] element;
    logic                         element_valid;
    logic [CNT_W-1:0]             count_after;
    logic [1:0]                   status;
    logic                         last_of_run;
  } store_result_t;

  // shadow copy of the word store and the queue of results it predicts
  class word_store_scoreboard;
    logic signed [DATA_WIDTH-1:0] model_words [DEPTH];
    int unsigned                  model_count;
    store_result_t                expected_results [$];
    int unsigned                  failures;

    function new();
      model_count = 0;
      failures    = 0;
    endfunction

    task report(string field, logic signed [63:0] got, logic signed [63:0] want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
      failures++;
    endtask

    function void push_result(logic signed [DATA_WIDTH-1:0] element, logic element_valid,
                              logic [1:0] status, logic last_of_run);
      store_result_t r;
      r.element       = element;
      r.element_valid = element_valid;
      r.count_after   = model_count[CNT_W-1:0];
      r.status        = status;
      r.last_of_run   = last_of_run;
      expected_results.push_back(r);
    endfunction

    // remove the word at a 1-based position, later words move toward the head
    function logic [1:0] delete_at(int unsigned pos);
      if (pos < 1 || pos > model_count) return ST_IGNORED;
      for (int unsigned i = pos - 1; i + 1 < model_count; i++) model_words[i] = model_words[i + 1];
      model_count--;
      return ST_DONE;
    endfunction

    // apply one accepted request and queue what it should produce
    function void note_request(logic [2:0] cmd, logic signed [DATA_WIDTH-1:0] value,
                               logic [7:0] position);
      logic [1:0] st;
      st = ST_IGNORED;
      case (cmd)
        CMD_APPEND: begin
          if (model_count >= DEPTH) begin
            st = ST_FULL;
          end else begin
            model_words[model_count] = value;
            model_count++;
            st = ST_DONE;
          end
        end
        CMD_DEL_HEAD:   st = delete_at(1);
        CMD_DEL_TAIL:   st = delete_at(model_count);
        CMD_DEL_POS:    st = delete_at(position);
        CMD_DEL_CENTER: st = delete_at(model_count / 2 + model_count % 2);
        CMD_DUMP: begin
          // a non-empty store streams head to tail, empty falls through as ignored
          if (model_count != 0) begin
            for (int unsigned i = 0; i < model_count; i++)
              push_result(model_words[i], 1'b1, ST_DONE, i + 1 == model_count);
            return;
          end
        end
        default: st = ST_IGNORED;
      endcase
      push_result('0, 1'b0, st, 1'b1);
    endfunction

    task check_result(logic signed [DATA_WIDTH-1:0] element, logic element_valid,
                      logic [CNT_W-1:0] count_after, logic [1:0] status, logic last_of_run);
      store_result_t want;
      if (expected_results.size() == 0) begin
        report("unexpected result, element", element, 0);
        return;
      end
      want = expected_results.pop_front();
      if (element !== want.element) report("element", element, want.element);
      if (element_valid !== want.element_valid)
        report("element_valid", element_valid, want.element_valid);
      if (count_after !== want.count_after) report("count_after", count_after, want.count_after);
      if (status !== want.status) report("status", status, want.status);
      if (last_of_run !== want.last_of_run) report("last_of_run", last_of_run, want.last_of_run);
    endtask
  endclass

  logic                         clk;
  logic                         rst_n       = 1'b0;
  logic                         in_valid    = 1'b0;
  logic [2:0]                   in_command  = '0;
  logic signed [DATA_WIDTH-1:0] in_value    = '0;
  logic [7:0]                   in_position = '0;
  logic                         out_stall   = 1'b0;
  logic                         in_stall;
  logic                         out_valid;
  logic signed [DATA_WIDTH-1:0] out_element;
  logic                         out_element_valid;
  logic [CNT_W-1:0]             out_count_after;
  logic [1:0]                   out_status;
  logic                         out_last_of_run;

  word_store_scoreboard sb;
  int unsigned          burst_left  = 0;
  int unsigned          items_sent  = 0;
  int unsigned          stall_mode  = 0;
  int unsigned          stall_left  = 0;
  int unsigned          cycle_count = 0;

  ordered_list_positional_delete_unit #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_value          (in_value),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_element       (out_element),
    .out_element_valid (out_element_valid),
    .out_count_after   (out_count_after),
    .out_status        (out_status),
    .out_last_of_run   (out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // present one request and hold it until taken; gaps open between bursts
  task automatic send_request(input logic [2:0] cmd, input logic signed [DATA_WIDTH-1:0] value,
                              input logic [7:0] position);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_value    <= value;
    in_position <= position;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(cmd, value, position);
    if (cmd != CMD_RESERVED_A && cmd != CMD_RESERVED_B) items_sent++;
  endtask

  // word values lean toward the signed extremes
  function automatic logic signed [DATA_WIDTH-1:0] random_word();
    case ($urandom_range(0, 7))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // mostly in range, some zero, some past the tail
  function automatic logic [7:0] pick_position();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return 8'd0;
    if (roll < 25) return 8'($urandom_range(sb.model_count + 1, 255));
    if (sb.model_count == 0) return 8'($urandom());
    return 8'($urandom_range(1, sb.model_count));
  endfunction

  // mixed traffic, appends favored while the store has room
  task automatic send_random_request();
    int unsigned roll;
    int unsigned append_weight;
    logic [2:0]  cmd;
    logic [7:0]  position;
    append_weight = (sb.model_count > 12) ? 20 : 45;
    position      = 8'($urandom());
    if ($urandom_range(0, 99) < append_weight) begin
      cmd = CMD_APPEND;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 15)      cmd = CMD_DEL_HEAD;
      else if (roll < 30) cmd = CMD_DEL_TAIL;
      else if (roll < 60) cmd = CMD_DEL_POS;
      else if (roll < 75) cmd = CMD_DEL_CENTER;
      else if (roll < 95) cmd = CMD_DUMP;
      else                cmd = $urandom_range(0, 1) ? CMD_RESERVED_A : CMD_RESERVED_B;
    end
    if (cmd == CMD_DEL_POS) position = pick_position();
    send_request(cmd, random_word(), position);
  endtask

  // receiver stall pattern: free, light, heavy or periodic stretches
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(30, 150);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_left % 5) < 2;
    endcase
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_element, out_element_valid, out_count_after, out_status,
                      out_last_of_run);
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL ordered_list_positional_delete_unit");
    $finish;
  end

  initial begin
    logic signed [DATA_WIDTH-1:0] corner_words [6];
    logic [2:0]                   delete_cmds [5];
    int unsigned                  episode;
    corner_words = '{32'sh7fffffff, 32'sh80000000, 32'sh0, -32'sd1, 32'sh55555555,
                     32'shaaaaaaaa};
    delete_cmds  = '{CMD_DEL_HEAD, CMD_DEL_TAIL, CMD_DEL_POS, CMD_DEL_CENTER, CMD_DUMP};
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty store: dump, center and an unknown code are all ignored
    send_request(CMD_DUMP, random_word(), 8'($urandom()));
    send_request(CMD_DEL_CENTER, random_word(), 8'($urandom()));
    send_request(CMD_RESERVED_A, random_word(), 8'($urandom()));
    // fill with corner words, then one append too many
    for (int i = 0; i < DEPTH; i++)
      send_request(CMD_APPEND, (i < 6) ? corner_words[i] : random_word(), 8'($urandom()));
    send_request(CMD_APPEND, random_word(), 8'($urandom()));
    send_request(CMD_DUMP, random_word(), 8'($urandom()));
    // positions zero and far past the tail, then each delete kind
    send_request(CMD_DEL_POS, random_word(), 8'd0);
    send_request(CMD_DEL_POS, random_word(), 8'd255);
    send_request(CMD_DEL_CENTER, random_word(), 8'($urandom()));
    send_request(CMD_DEL_HEAD, random_word(), 8'($urandom()));
    send_request(CMD_DEL_TAIL, random_word(), 8'($urandom()));
    send_request(CMD_DEL_POS, random_word(), 8'd3);
    send_request(CMD_RESERVED_B, random_word(), 8'($urandom()));

    // random episodes: fill to full, drain to empty, or mixed traffic
    while (items_sent < REQUEST_TARGET) begin
      episode = $urandom_range(0, 9);
      if (episode == 0) begin
        while (sb.model_count < DEPTH) send_request(CMD_APPEND, random_word(), 8'($urandom()));
        repeat ($urandom_range(1, 2)) send_request(CMD_APPEND, random_word(), 8'($urandom()));
      end else if (episode == 1) begin
        while (sb.model_count != 0)
          send_request(delete_cmds[$urandom_range(0, 3)], random_word(), pick_position());
        repeat ($urandom_range(1, 3))
          send_request(delete_cmds[$urandom_range(0, 4)], random_word(), pick_position());
      end else begin
        repeat ($urandom_range(1, 8)) send_random_request();
      end
    end
    in_valid <= 1'b0;

    // let every predicted result arrive, then watch for strays
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0)
      $display("PASS ordered_list_positional_delete_unit");
    else
      $display("FAIL ordered_list_positional_delete_unit");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/olpd_pkg.sv
hdl/olpd_cell.sv
hdl/ordered_list_positional_delete_unit.sv
tb/sv/ordered_list_positional_delete_unit_test.sv
